[rtl/core/rc_link_frame_receiver_top_defines.svh]
// assertion macros for the checker file
`ifndef RC_LINK_FRAME_RECEIVER_TOP_DEFINES_SVH
`define RC_LINK_FRAME_RECEIVER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RCLFR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rclfr check failed");

// next-cycle implication, sampled on clk, off during reset
`define RCLFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rclfr check failed");

`endif

[rtl/core/rclfr_pkg.sv]
package rclfr_pkg;

	localparam int MAX_FRAME_BYTES = 16;
	localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int POS_W = $clog2(MAX_FRAME_BYTES);

	localparam int NUM_BUFS = 2;
	localparam int BUF_W = $clog2(NUM_BUFS);
	localparam int PEND_W = $clog2(NUM_BUFS + 1);
	localparam int STORE_DEPTH = NUM_BUFS * MAX_FRAME_BYTES;
	localparam int STORE_AW = BUF_W + POS_W;

	localparam int QUEUE_DEPTH = NUM_BUFS;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// frame length arithmetic: length byte + 2 reaches 257
	localparam int LEN_W = 9;
	localparam logic [LEN_W-1:0] ASSUMED_FRAME_LEN = 9'd5;
	localparam logic [LEN_W-1:0] LEN_EXTRA = 9'd2;
	localparam logic [LEN_W-1:0] HDR_AND_CRC = 9'd3;
	localparam int HDR_BYTES = 3;
	localparam int TYPE_POS = 2;
	localparam int LEN_POS = 1;

	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIMEOUT = 1'b1;
	localparam logic [7:0] OWN_ADDRESS_RST = 8'd130;
	localparam logic [15:0] TIMEOUT_RST = 16'd500;

	localparam logic [7:0] CRC_POLY = 8'hD5;

	typedef struct packed {
		logic [BUF_W-1:0] buf_id;
		logic ok;
		logic [IDX_W-1:0] count;
	} desc_t;

	typedef struct packed {
		logic we;
		logic [STORE_AW-1:0] addr;
		logic [7:0] data;
	} store_wr_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

[rtl/core/rc_link_frame_receiver_top.sv]
// Receives serial bytes with microsecond timestamps, one byte per clock when
// full is low, and assembles address/length/type/payload/crc frames into one of
// two frame buffers. A frame addressed to own_address is handed to the drain
// side, which delivers its type and payload bytes with the crc verdict. The
// input side only stalls (full high) while both frame buffers hold frames that
// are not yet fully taken. Each result passes the drain side's store read, load
// and show steps and then waits for pop, and the next result of a frame is read
// only after that pop; the single registered read port of the frame store sets
// this order. Register writes take effect at the next edge.
module rc_link_frame_receiver_top import rclfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           rx_byte,
	input  logic [31:0]          rx_time_us,
	output logic                 empty,
	input  logic                 pop,
	output logic                 frame_ok,
	output logic [3:0]           byte_pos,
	output logic [7:0]           data_byte,
	output logic                 last
);

	store_wr_t           wr;
	logic                desc_push;
	desc_t               desc_in;
	desc_t               desc_out;
	logic                desc_valid;
	logic                desc_pop;
	logic                buf_free;
	logic                rd_en;
	logic [STORE_AW-1:0] rd_addr;
	logic [7:0]          rd_data;

	rclfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.rx_byte    (rx_byte),
		.rx_time_us (rx_time_us),
		.wr         (wr),
		.desc_push  (desc_push),
		.desc       (desc_in),
		.buf_free   (buf_free)
	);

	rclfr_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	rclfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (desc_push),
		.wr_desc  (desc_in),
		.rd_en    (desc_pop),
		.rd_desc  (desc_out),
		.rd_valid (desc_valid)
	);

	rclfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (desc_valid),
		.q_desc    (desc_out),
		.q_pop     (desc_pop),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.buf_free  (buf_free),
		.empty     (empty),
		.pop       (pop),
		.frame_ok  (frame_ok),
		.byte_pos  (byte_pos),
		.data_byte (data_byte),
		.last      (last)
	);

endmodule

[rtl/core/rclfr_ram.sv]
module rclfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/rclfr_front.sv]
module rclfr_front import rclfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           rx_byte,
	input  logic [31:0]          rx_time_us,
	output store_wr_t            wr,
	output logic                 desc_push,
	output desc_t                desc,
	input  logic                 buf_free
);

	logic [7:0]        own_q;
	logic [15:0]       tmo_q;
	logic [IDX_W-1:0]  idx_q;
	logic [31:0]       start_q;
	logic [7:0]        crc_q;
	logic [7:0]        addr_q;
	logic [7:0]        len_q;
	logic [BUF_W-1:0]  wbuf_q;
	logic [PEND_W-1:0] pend_q;

	logic              accept;
	logic [31:0]       elapsed;
	logic              expired;
	logic [IDX_W-1:0]  idx0;
	logic              fresh;
	logic [7:0]        crc0;
	logic [31:0]       start0;
	logic [LEN_W-1:0]  frame_len;
	logic              take;
	logic [IDX_W-1:0]  idx_nx;
	logic              is_crc_byte;
	logic              done;
	logic [7:0]        crc_nx;

	always_comb begin
		accept = push && !full;
		elapsed = rx_time_us - start_q;
		expired = elapsed > {16'd0, tmo_q};
		idx0 = expired ? '0 : idx_q;
		fresh = (idx0 == '0);
		crc0 = fresh ? 8'd0 : crc_q;
		start0 = fresh ? rx_time_us : start_q;
		frame_len = (idx0 < IDX_W'(HDR_BYTES)) ? ASSUMED_FRAME_LEN
			: ({1'b0, len_q} + LEN_EXTRA);
		take = (LEN_W'(idx0) < frame_len) && (idx0 < IDX_W'(MAX_FRAME_BYTES));
		idx_nx = idx0 + IDX_W'(1);
		is_crc_byte = (LEN_W'(idx_nx) == frame_len);
		done = take && is_crc_byte;
		crc_nx = (take && idx0 >= IDX_W'(TYPE_POS) && !is_crc_byte)
			? crc8_update(crc0, rx_byte) : crc0;
	end

	assign full = (pend_q == PEND_W'(NUM_BUFS));
	assign desc_push = accept && done && (addr_q == own_q);

	always_comb begin
		desc.buf_id = wbuf_q;
		desc.ok = (crc0 == rx_byte);
		desc.count = IDX_W'(frame_len - HDR_AND_CRC);
		wr.we = accept && take;
		wr.addr = {wbuf_q, idx0[POS_W-1:0]};
		wr.data = rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= OWN_ADDRESS_RST;
			tmo_q <= TIMEOUT_RST;
			idx_q <= '0;
			start_q <= '0;
			crc_q <= '0;
			wbuf_q <= '0;
			pend_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OWN_ADDRESS: own_q <= cfg_data[7:0];
					REG_FRAME_TIMEOUT: tmo_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				start_q <= start0;
				crc_q <= crc_nx;
				if (done) begin
					idx_q <= '0;
				end else if (take) begin
					idx_q <= idx_nx;
				end else begin
					idx_q <= idx0;
				end
			end
			if (desc_push) begin
				wbuf_q <= wbuf_q + BUF_W'(1);
			end
			if (desc_push && !buf_free) begin
				pend_q <= pend_q + PEND_W'(1);
			end else if (!desc_push && buf_free) begin
				pend_q <= pend_q - PEND_W'(1);
			end
		end
	end

	// address and length bytes of the frame in progress
	always_ff @(posedge clk) begin
		if (accept && take && idx0 == '0) begin
			addr_q <= rx_byte;
		end
		if (accept && take && idx0 == IDX_W'(LEN_POS)) begin
			len_q <= rx_byte;
		end
	end

endmodule

[rtl/core/rclfr_queue.sv]
module rclfr_queue import rclfr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  desc_t wr_desc,
	input  logic  rd_en,
	output desc_t rd_desc,
	output logic  rd_valid
);

	desc_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wptr_q;
	logic [QPTR_W-1:0]  rptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign rd_valid = (cnt_q != '0);
	assign rd_desc = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= ptr_inc(wptr_q);
			end
			if (rd_en) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

[rtl/core/rclfr_back.sv]
module rclfr_back import rclfr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  desc_t               q_desc,
	output logic                q_pop,
	output logic                rd_en,
	output logic [STORE_AW-1:0] rd_addr,
	input  logic [7:0]          rd_data,
	output logic                buf_free,
	output logic                empty,
	input  logic                pop,
	output logic                frame_ok,
	output logic [3:0]          byte_pos,
	output logic [7:0]          data_byte,
	output logic                last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_HOLD
	} state_t;

	state_t           state_q;
	desc_t            cur_q;
	logic [IDX_W-1:0] i_q;
	logic             vld_q;
	logic             ok_q;
	logic [3:0]       pos_q;
	logic [7:0]       data_q;
	logic             last_q;

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign rd_en = (state_q == ST_READ);
	assign rd_addr = {cur_q.buf_id, POS_W'(i_q + IDX_W'(TYPE_POS))};
	assign buf_free = (state_q == ST_HOLD) && pop && last_q;

	assign empty = !vld_q;
	assign frame_ok = ok_q;
	assign byte_pos = pos_q;
	assign data_byte = data_q;
	assign last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q <= '0;
			i_q <= '0;
			vld_q <= 1'b0;
			ok_q <= 1'b0;
			pos_q <= '0;
			data_q <= '0;
			last_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cur_q <= q_desc;
						i_q <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					ok_q <= cur_q.ok;
					pos_q <= 4'(i_q);
					data_q <= rd_data;
					last_q <= (i_q + IDX_W'(1) == cur_q.count);
					vld_q <= 1'b1;
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (pop) begin
						vld_q <= 1'b0;
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + IDX_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/rclfr_checker.sv]
`include "rc_link_frame_receiver_top_defines.svh"

module rclfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       frame_ok,
	input logic [3:0] byte_pos,
	input logic [7:0] data_byte,
	input logic       last
);

	// a waiting result stays put until its transfer
	`RCLFR_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(data_byte) && $stable(byte_pos) && $stable(frame_ok) && $stable(last))

	// the drain side needs a store read after every transfer
	`RCLFR_ASSERT_NEXT(a_gap_after_transfer, !empty && pop, empty)

	// inside a frame the next result follows at the next position, same verdict
	`RCLFR_ASSERT_NEXT(a_frame_continues, !empty && pop && !last, empty ##1 empty ##1 (!empty && byte_pos == $past(byte_pos, 3) + 4'd1 && frame_ok == $past(frame_ok, 3)))

endmodule

bind rc_link_frame_receiver_top rclfr_checker u_rclfr_checker (.*);

[dv/tb_rc_link_frame_receiver_top.sv]
`timescale 1ns / 100ps

module tb_rc_link_frame_receiver_top;
	import rclfr_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 60;
	localparam int DIR_ROWS = 25;

	typedef enum {FR_GOOD, FR_FOREIGN, FR_SHORT, FR_LONG, FR_BROKEN, FR_NOISE} frame_kind_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] pos;
		logic [7:0] data;
		logic       last;
	} out_byte_t;

	typedef struct packed {
		logic [7:0]  b;
		logic [15:0] dt;
		logic        crc_fill;
		logic        typed;
		logic [3:0]  n_exp;
		logic        ok_exp;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_OWN_ADDRESS;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 push = 1'b0;
	logic                 full;
	logic [7:0]           rx_byte = 8'h00;
	logic [31:0]          rx_time_us = 32'h0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic                 frame_ok;
	logic [3:0]           byte_pos;
	logic [7:0]           data_byte;
	logic                 last;

	rc_link_frame_receiver_top dut (.*);

	always #2 clk = ~clk;

	// receiver state as the block should hold it
	logic [7:0]  rx_store [MAX_FRAME_BYTES];
	int          fill_idx = 0;
	logic [31:0] frame_t0 = 32'h0;
	logic [7:0]  crc_acc = 8'h00;
	logic [7:0]  cur_addr = OWN_ADDRESS_RST;
	logic [15:0] cur_timeout = TIMEOUT_RST;

	out_byte_t   due_out_q [$];
	out_byte_t   head;
	logic [31:0] now_us = 32'hFFFF_FF80;
	int          err_cnt = 0;
	int          items_sent = 0;
	int          bytes_checked = 0;
	int          stall_cycles = 0;
	int          cycle_cnt = 0;
	int          hold_left = 0;
	bit          hold_req = 1'b0;
	bit          hold_done = 1'b0;
	bit          no_idle = 1'b0;

	// min length ok, crc error, foreign address, short length stall, timeout resync,
	// elapsed exactly at the timeout; the timeout resync crosses the timestamp wrap
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{8'h82, 16'd0,   1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h02, 16'd3,   1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h00, 16'd3,   1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h00, 16'd3,   1'b0, 1'b1, 4'd1, 1'b1},
		'{8'h82, 16'd10,  1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h02, 16'd1,   1'b0, 1'b0, 4'd0, 1'b0},
		'{8'hFF, 16'd1,   1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h00, 16'd1,   1'b0, 1'b1, 4'd1, 1'b0},
		'{8'hFF, 16'd5,   1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h02, 16'd1,   1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h00, 16'd1,   1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h00, 16'd1,   1'b0, 1'b1, 4'd0, 1'b0},
		'{8'h82, 16'd5,   1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h00, 16'd1,   1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h55, 16'd1,   1'b0, 1'b0, 4'd0, 1'b0},
		'{8'hAA, 16'd1,   1'b0, 1'b1, 4'd0, 1'b0},
		'{8'h82, 16'd501, 1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h03, 16'd2,   1'b0, 1'b0, 4'd0, 1'b0},
		'{8'hA5, 16'd2,   1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h5A, 16'd2,   1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h00, 16'd2,   1'b1, 1'b1, 4'd2, 1'b1},
		'{8'h82, 16'd7,   1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h02, 16'd100, 1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h00, 16'd400, 1'b0, 1'b0, 4'd0, 1'b0},
		'{8'h00, 16'd0,   1'b1, 1'b1, 4'd1, 1'b1}
	};

	function automatic logic [7:0] dvb_crc_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		int         k;
		c = crc;
		for (k = 7; k >= 0; k--) begin
			fb = c[7] ^ b[k];
			c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	// one accepted byte; queues the frame bytes it releases, returns their number
	function automatic int absorb_rx_byte(input logic [7:0] b, input logic [31:0] t,
		output logic ok);
		int flen;
		int n;
		int i;
		ok = 1'b0;
		if (t - frame_t0 > {16'h0, cur_timeout})
			fill_idx = 0;
		if (fill_idx == 0) begin
			frame_t0 = t;
			crc_acc = 8'h00;
		end
		flen = (fill_idx < HDR_BYTES) ? int'(ASSUMED_FRAME_LEN) : int'(rx_store[LEN_POS]) + 2;
		if (fill_idx >= flen || fill_idx >= MAX_FRAME_BYTES)
			return 0;
		rx_store[fill_idx] = b;
		if (fill_idx >= TYPE_POS && fill_idx + 1 != flen)
			crc_acc = dvb_crc_next(crc_acc, b);
		fill_idx++;
		if (fill_idx < flen)
			return 0;
		fill_idx = 0;
		if (rx_store[0] != cur_addr)
			return 0;
		n = flen - HDR_BYTES;
		ok = (crc_acc == rx_store[flen - 1]);
		for (i = 0; i < n; i++)
			due_out_q.push_back(out_byte_t'{ok, 4'(i), rx_store[TYPE_POS + i], i == n - 1});
		return n;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic [31:0] t, output int n,
		output logic ok);
		while (!no_idle && $urandom_range(99) < 36) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		rx_time_us <= t;
		@(posedge clk);
		while (full)
			@(posedge clk);
		n = absorb_rx_byte(b, t, ok);
		items_sent++;
	endtask

	task automatic send_frame(input frame_kind_t kind);
		logic [7:0]  fb [$];
		logic [7:0]  crc;
		logic [7:0]  d;
		logic [7:0]  a;
		logic [31:0] dt;
		logic        ok;
		int          tmo;
		int          flen;
		int          sel;
		int          brk;
		int          el;
		int          i;
		int          n;
		tmo = cur_timeout;
		crc = 8'h00;
		a = cur_addr;
		if (kind == FR_FOREIGN) begin
			do a = 8'($urandom); while (a == cur_addr);
		end
		case (kind)
			FR_SHORT: begin
				fb.push_back(a);
				fb.push_back(8'($urandom_range(1)));
				repeat (3) fb.push_back(8'($urandom));
			end
			FR_LONG: begin
				fb.push_back(a);
				fb.push_back(8'($urandom_range(15, 255)));
				repeat ($urandom_range(14, 18)) fb.push_back(8'($urandom));
			end
			FR_NOISE: begin
				repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom));
			end
			default: begin
				sel = $urandom_range(9);
				flen = (sel == 0) ? 2 : (sel == 1) ? MAX_FRAME_BYTES - 2 : $urandom_range(2, 14);
				fb.push_back(a);
				fb.push_back(8'(flen));
				repeat (flen - 1) begin
					d = 8'($urandom);
					fb.push_back(d);
					crc = dvb_crc_next(crc, d);
				end
				if ($urandom_range(4) == 0)
					crc = crc ^ 8'($urandom_range(1, 255));
				fb.push_back(crc);
			end
		endcase
		brk = (kind == FR_BROKEN) ? $urandom_range(1, fb.size() - 1) : 0;
		// gap ahead of the frame; a half-built frame is left to time out first, but noise is not
		if (kind == FR_NOISE)
			dt = $urandom_range(0, 2 * tmo);
		else if (fill_idx != 0)
			dt = tmo + 1 + $urandom_range(20);
		else if ($urandom_range(3) == 0)
			dt = $urandom;
		else
			dt = $urandom_range(0, 2 * tmo);
		el = 0;
		for (i = 0; i < fb.size(); i++) begin
			if (i > 0) begin
				if (i == brk) begin
					dt = tmo + 1 - el + $urandom_range(3);
					el = 0;
				end else if (i == fb.size() - 1 && el <= tmo && $urandom_range(5) == 0) begin
					dt = tmo - el;
					el = tmo;
				end else begin
					dt = $urandom_range(0, tmo / 16);
					el += dt;
				end
			end
			now_us = now_us + dt;
			send_byte(fb[i], now_us, n, ok);
		end
	endtask

	task automatic settle();
		push <= 1'b0;
		while (due_out_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_OWN_ADDRESS: cur_addr = val[7:0];
			REG_FRAME_TIMEOUT: cur_timeout = val;
			default: ;
		endcase
	endtask

	// output side: random pop, one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
		pop <= (hold_left == 0) && (no_idle || $urandom_range(99) >= 36);
	end

	always @(posedge clk) begin
		if (arst_n && push && full)
			stall_cycles++;
		if (arst_n && pop && !empty) begin
			if (due_out_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected transfer, expected none, actual %0b %0d %02h %0b",
					$time, frame_ok, byte_pos, data_byte, last);
			end else begin
				head = due_out_q.pop_front();
				bytes_checked++;
				if (frame_ok !== head.ok || byte_pos !== head.pos || data_byte !== head.data ||
					last !== head.last) begin
					err_cnt++;
					$display("%0t: expected %0b %0d %02h %0b, actual %0b %0d %02h %0b",
						$time, head.ok, head.pos, head.data, head.last,
						frame_ok, byte_pos, data_byte, last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d output bytes outstanding", $time, due_out_q.size());
			$display("tb_rc_link_frame_receiver_top: FAIL");
			$finish;
		end
	end

	initial begin
		dir_row_t    row;
		frame_kind_t kind;
		logic [7:0]  rb;
		logic [7:0]  addr_pick;
		logic [15:0] tmo_pick;
		logic        ok;
		int          k;
		int          n;
		int          ph;
		int          r;
		int          start_cnt;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < DIR_ROWS; k++) begin
			row = dir_rows[k];
			rb = row.crc_fill ? crc_acc : row.b;
			now_us = now_us + row.dt;
			send_byte(rb, now_us, n, ok);
			if (row.typed && (n != row.n_exp || (n != 0 && ok !== row.ok_exp))) begin
				err_cnt++;
				$display("%0t: row %0d, expected %0d bytes ok=%0b, actual %0d bytes ok=%0b",
					$time, k, row.n_exp, row.ok_exp, n, ok);
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				case (ph)
					1: begin
						addr_pick = 8'h00;
						tmo_pick = 16'd1;
					end
					2: begin
						addr_pick = 8'hFF;
						tmo_pick = 16'hFFFF;
					end
					3: begin
						addr_pick = 8'($urandom);
						tmo_pick = 16'($urandom_range(100, 3000));
					end
					4: begin
						addr_pick = OWN_ADDRESS_RST;
						tmo_pick = 16'($urandom_range(1, 65535));
					end
					default: begin
						addr_pick = 8'($urandom);
						tmo_pick = 16'($urandom_range(2, 40));
					end
				endcase
				settle();
				write_reg(REG_OWN_ADDRESS, {8'($urandom), addr_pick});
				write_reg(REG_FRAME_TIMEOUT, tmo_pick);
				cfg_we <= 1'b0;
			end
			no_idle <= (ph == 2);
			if (ph == 3)
				hold_req <= 1'b1;
			start_cnt = items_sent;
			while (items_sent - start_cnt < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (ph == 3 || r < 62)
					kind = FR_GOOD;
				else if (r < 72)
					kind = FR_FOREIGN;
				else if (r < 78)
					kind = FR_SHORT;
				else if (r < 84)
					kind = FR_LONG;
				else if (r < 93)
					kind = FR_BROKEN;
				else
					kind = FR_NOISE;
				send_frame(kind);
			end
			// leave the receiver between frames before the next register write
			send_frame(FR_GOOD);
		end
		settle();

		$display("%0d bytes sent under %0d register settings, %0d output bytes checked",
			items_sent, PHASES, bytes_checked);
		$display("input stalled by full on %0d cycles", stall_cycles);
		if (err_cnt == 0 && due_out_q.size() == 0)
			$display("tb_rc_link_frame_receiver_top: PASS");
		else
			$display("tb_rc_link_frame_receiver_top: FAIL");
		$finish;
	end

endmodule
